>>> hdl/pta_pkg.sv
// Shared types, widths and constants for the pixel to aim angle pipeline.
`default_nettype none
package pta_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int CORDIC_MAX_STAGES = 32;

   localparam int PIX_W  = 16;
   localparam int D_W    = PIX_W + 1;
   localparam int INV_W  = 24;
   localparam int NP_W   = D_W + INV_W + 1;
   localparam int X1_W   = 26;
   localparam int SQ_W   = 28;
   localparam int R2_W   = 29;
   localparam int S_W    = 30;
   localparam int R4_W   = 32;
   localparam int COEF_W = 32;
   localparam int A_W    = 34;
   localparam int B_W    = 37;
   localparam int T_W    = 31;
   localparam int F_W    = 38;
   localparam int V_W    = 40;
   localparam int GOFF_W = 26;
   localparam int GUN_W  = 11;
   localparam int COMP_W = 24;
   localparam int CW     = 42;
   localparam int Z_W    = 32;
   localparam int YAW_W  = 24;
   localparam int PITCH_W = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int ONE_Q24     = 1 << 24;
   localparam int YAW_LIMIT   = 5898240;
   localparam int PITCH_LIMIT = 11796480;

   // gun offset scale: 2^24 = 16777 * 1000 + 216
   localparam int MM_WHOLE    = 16777;
   localparam int MM_FRAC     = 216;
   localparam int MM_HALF     = 500;
   localparam int RECIP_1000  = 268436;   // ceil(2^28 / 1000)
   localparam int RECIP_SHIFT = 28;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PRINCIPAL  = 3'd0,
      REG_INV_FOCAL  = 3'd1,
      REG_K1         = 3'd2,
      REG_K2         = 3'd3,
      REG_TANGENTIAL = 3'd4,
      REG_GUN_OFFSET = 3'd5,
      REG_RUNE_COMP  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        [PIX_W-1:0]  cx;
      logic        [PIX_W-1:0]  cy;
      logic        [INV_W-1:0]  ifx;
      logic        [INV_W-1:0]  ify;
      logic signed [COEF_W-1:0] k1;
      logic signed [COEF_W-1:0] k2;
      logic signed [COEF_W-1:0] p1;
      logic signed [COEF_W-1:0] p2;
      logic signed [COMP_W-1:0] comp;
      logic signed [GOFF_W-1:0] goff;
   } cfg_type;

   // atan(2^-i) in degrees, Q.24
   localparam logic signed [Z_W-1:0] ATAN_DEG_Q24 [CORDIC_MAX_STAGES] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938, 32'sd60000934,
      32'sd30029717, 32'sd15018523, 32'sd7509720, 32'sd3754917, 32'sd1877466,
      32'sd938734, 32'sd469367, 32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
      32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833, 32'sd917, 32'sd458, 32'sd229,
      32'sd115, 32'sd57, 32'sd29, 32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0
   };

endpackage
`default_nettype wire

>>> hdl/pixel_to_aim_angle.sv
// A req beat passes nine stages of normalization and distortion, one CORDIC stage per
// iteration and one output register with rounding, rune compensation and saturation.
// Every stage has its own valid bit, so a new beat is taken every cycle while rsp_tready
// is high, and bubbles close up under back-pressure.
// Configuration written on the csr port is registered in pta_csr before it applies to beats.
`default_nettype none
module pixel_to_aim_angle
   import pta_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // pixel_x[15:0], pixel_y[31:16]
   input  wire logic                  req_tuser,   // rune_target
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [55:0]                rsp_tdata,   // yaw_deg[23:0], pitch_deg[48:24], zero
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type               cfg;
   logic                  fr_valid, fr_ready, fr_rune;
   logic signed [V_W-1:0] fr_vx, fr_vy;
   logic                  cd_valid, cd_ready, cd_rune;
   logic signed [Z_W-1:0] cd_zx, cd_zy;

   pta_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pta_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .px        (req_tdata[PIX_W-1:0]),
      .py        (req_tdata[2*PIX_W-1:PIX_W]),
      .rune      (req_tuser),
      .cfg       (cfg),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .vx        (fr_vx),
      .vy        (fr_vy),
      .out_rune  (fr_rune)
   );

   pta_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .vx        (fr_vx),
      .vy        (fr_vy),
      .in_rune   (fr_rune),
      .out_valid (cd_valid),
      .out_ready (cd_ready),
      .zx        (cd_zx),
      .zy        (cd_zy),
      .out_rune  (cd_rune)
   );

   // output stage: round Q.24 to Q.16, compensate, saturate
   logic                      out_adv;
   logic                      rsp_valid_ff;
   logic signed [YAW_W-1:0]   yaw_ff, yaw_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [Z_W:0]       qx, qy;
   logic signed [Z_W+1:0]     pc;

   assign out_adv  = !rsp_valid_ff || rsp_tready;
   assign cd_ready = out_adv;

   always_comb begin
      qx = ((Z_W+1)'(cd_zx) + (Z_W+1)'(128)) >>> 8;
      qy = ((Z_W+1)'(cd_zy) + (Z_W+1)'(128)) >>> 8;
      pc = (Z_W+2)'(qy) - (cd_rune ? (Z_W+2)'(cfg.comp) : '0);
      if (qx > YAW_LIMIT) begin
         yaw_in = YAW_W'(YAW_LIMIT);
      end else if (qx < -YAW_LIMIT) begin
         yaw_in = YAW_W'(-YAW_LIMIT);
      end else begin
         yaw_in = qx[YAW_W-1:0];
      end
      if (pc > PITCH_LIMIT) begin
         pitch_in = PITCH_W'(PITCH_LIMIT);
      end else if (pc < -PITCH_LIMIT) begin
         pitch_in = PITCH_W'(-PITCH_LIMIT);
      end else begin
         pitch_in = pc[PITCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, pitch_ff, yaw_ff};

   yaw_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (yaw_ff <= YAW_LIMIT && yaw_ff >= -YAW_LIMIT))
      else $error("yaw out of range");

   pitch_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pitch_ff <= PITCH_LIMIT && pitch_ff >= -PITCH_LIMIT))
      else $error("pitch out of range");

   ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   held_result_stays: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("output changed while held");

endmodule
`default_nettype wire

>>> hdl/pta_csr.sv
// Configuration registers and the derived gun offset in normalized units.
`default_nettype none
module pta_csr
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type                    cfg
);

   logic        [2*PIX_W-1:0]  pp_ff;
   logic        [2*INV_W-1:0]  inv_ff;
   logic signed [COEF_W-1:0]   k1_ff;
   logic signed [COEF_W-1:0]   k2_ff;
   logic        [2*COEF_W-1:0] tan_ff;
   logic signed [GUN_W-1:0]    gun_ff;
   logic signed [COMP_W-1:0]   comp_ff;
   logic signed [GOFF_W-1:0]   goff_ff;

   logic        [GUN_W-1:0]    gun_mag;
   logic        [GOFF_W-1:0]   goff_whole;
   logic        [17:0]         frac_num;
   logic        [36:0]         frac_prod;
   logic        [GOFF_W-1:0]   goff_mag;
   logic signed [GOFF_W-1:0]   goff_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff   <= '0;
         inv_ff  <= '0;
         k1_ff   <= '0;
         k2_ff   <= '0;
         tan_ff  <= '0;
         gun_ff  <= '0;
         comp_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_PRINCIPAL:  pp_ff   <= csr_wr_data[2*PIX_W-1:0];
            REG_INV_FOCAL:  inv_ff  <= csr_wr_data[2*INV_W-1:0];
            REG_K1:         k1_ff   <= csr_wr_data[COEF_W-1:0];
            REG_K2:         k2_ff   <= csr_wr_data[COEF_W-1:0];
            REG_TANGENTIAL: tan_ff  <= csr_wr_data;
            REG_GUN_OFFSET: gun_ff  <= csr_wr_data[GUN_W-1:0];
            REG_RUNE_COMP:  comp_ff <= csr_wr_data[COMP_W-1:0];
            default: ;
         endcase
      end
   end

   // round(|g| * 2^24 / 1000), remainder part divided by reciprocal multiply
   always_comb begin
      gun_mag    = gun_ff[GUN_W-1] ? GUN_W'(-gun_ff) : GUN_W'(gun_ff);
      goff_whole = GOFF_W'(gun_mag) * GOFF_W'(MM_WHOLE);
      frac_num   = 18'(gun_mag) * 18'(MM_FRAC) + 18'(MM_HALF);
      frac_prod  = 37'(frac_num) * 37'(RECIP_1000);
      goff_mag   = goff_whole + GOFF_W'(frac_prod >> RECIP_SHIFT);
      goff_in    = gun_ff[GUN_W-1] ? -$signed(goff_mag) : $signed(goff_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goff_ff <= '0;
      end else begin
         goff_ff <= goff_in;
      end
   end

   assign cfg.cx   = pp_ff[PIX_W-1:0];
   assign cfg.cy   = pp_ff[2*PIX_W-1:PIX_W];
   assign cfg.ifx  = inv_ff[INV_W-1:0];
   assign cfg.ify  = inv_ff[2*INV_W-1:INV_W];
   assign cfg.k1   = k1_ff;
   assign cfg.k2   = k2_ff;
   assign cfg.p1   = $signed(tan_ff[COEF_W-1:0]);
   assign cfg.p2   = $signed(tan_ff[2*COEF_W-1:COEF_W]);
   assign cfg.comp = comp_ff;
   assign cfg.goff = goff_ff;

endmodule
`default_nettype wire

>>> hdl/pta_front.sv
// Normalization and forward distortion pipeline, nine register stages.
`default_nettype none
module pta_front
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [PIX_W-1:0]      px,
   input  wire logic [PIX_W-1:0]      py,
   input  wire logic                  rune,
   input  wire cfg_type               cfg,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic signed [V_W-1:0]      vx,
   output logic signed [V_W-1:0]      vy,
   output logic                       out_rune
);

   localparam int NF = 9;

   logic [NF-1:0] v_ff;
   logic [NF-1:0] rune_ff;
   logic [NF:0]   adv;

   assign adv[NF] = out_ready;
   for (genvar k = 0; k < NF; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NF; k++) begin
            if (adv[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NF; k++) begin
         if (adv[k]) begin
            rune_ff[k] <= (k == 0) ? rune : rune_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // stage 0: offset from principal point times reciprocal focal length
   logic signed [D_W-1:0]  dx_in, dy_in;
   logic signed [NP_W-1:0] npx_in, npy_in, npx_ff, npy_ff;
   assign dx_in  = $signed({1'b0, px}) - $signed({1'b0, cfg.cx});
   assign dy_in  = $signed({1'b0, py}) - $signed({1'b0, cfg.cy});
   assign npx_in = NP_W'(dx_in) * NP_W'($signed({1'b0, cfg.ifx}));
   assign npy_in = NP_W'(dy_in) * NP_W'($signed({1'b0, cfg.ify}));
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         npx_ff <= npx_in;
         npy_ff <= npy_in;
      end
   end

   // stage 1: drop the Q.4 pixel fraction, saturate to [-2, 2)
   function automatic logic signed [X1_W-1:0] sat_norm(input logic signed [NP_W-1:0] p);
      logic signed [NP_W-1:0] sh;
      logic                   fits;
      sh   = p >>> 4;
      fits = (&sh[NP_W-1:X1_W-1]) || !(|sh[NP_W-1:X1_W-1]);
      if (fits) begin
         sat_norm = sh[X1_W-1:0];
      end else if (sh[NP_W-1]) begin
         sat_norm = {1'b1, {(X1_W-1){1'b0}}};
      end else begin
         sat_norm = {1'b0, {(X1_W-1){1'b1}}};
      end
   endfunction

   logic signed [X1_W-1:0] x1_1_ff, y1_1_ff;
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         x1_1_ff <= sat_norm(npx_ff);
         y1_1_ff <= sat_norm(npy_ff);
      end
   end

   // stage 2: squares and cross product
   localparam int P2_W = 2 * X1_W;
   logic signed [SQ_W-1:0] xx_ff, yy_ff, xy_2_ff;
   logic signed [X1_W-1:0] x1_2_ff, y1_2_ff;
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         xx_ff   <= SQ_W'((P2_W'(x1_1_ff) * P2_W'(x1_1_ff)) >>> 24);
         yy_ff   <= SQ_W'((P2_W'(y1_1_ff) * P2_W'(y1_1_ff)) >>> 24);
         xy_2_ff <= SQ_W'((P2_W'(x1_1_ff) * P2_W'(y1_1_ff)) >>> 24);
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
      end
   end

   // stage 3: r^2 and the tangential sums
   logic signed [R2_W-1:0] r2_in, r2_ff;
   logic signed [S_W-1:0]  sx_ff, sy_ff;
   logic signed [SQ_W-1:0] xy_3_ff;
   logic signed [X1_W-1:0] x1_3_ff, y1_3_ff;
   assign r2_in = R2_W'(xx_ff) + R2_W'(yy_ff);
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         r2_ff   <= r2_in;
         sx_ff   <= S_W'(r2_in) + (S_W'(xx_ff) <<< 1);
         sy_ff   <= S_W'(r2_in) + (S_W'(yy_ff) <<< 1);
         xy_3_ff <= xy_2_ff;
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
      end
   end

   // stage 4: r^4, k1 term, tangential products
   localparam int PR4_W = 2 * R2_W;
   localparam int PA_W  = COEF_W + R2_W;
   localparam int PXY_W = COEF_W + SQ_W;
   localparam int PS_W  = COEF_W + S_W;
   logic signed [R4_W-1:0] r4_ff;
   logic signed [A_W-1:0]  a_4_ff;
   logic signed [T_W-1:0]  tx1_ff, tx2_ff, ty1_ff, ty2_ff;
   logic signed [X1_W-1:0] x1_4_ff, y1_4_ff;
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         r4_ff   <= R4_W'((PR4_W'(r2_ff) * PR4_W'(r2_ff)) >>> 24);
         a_4_ff  <= A_W'((PA_W'(cfg.k1) * PA_W'(r2_ff)) >>> 28);
         // 2*p*xy >> 30 taken as p*xy >> 29
         tx1_ff  <= T_W'((PXY_W'(cfg.p1) * PXY_W'(xy_3_ff)) >>> 29);
         ty1_ff  <= T_W'((PXY_W'(cfg.p2) * PXY_W'(xy_3_ff)) >>> 29);
         tx2_ff  <= T_W'((PS_W'(cfg.p2) * PS_W'(sx_ff)) >>> 30);
         ty2_ff  <= T_W'((PS_W'(cfg.p1) * PS_W'(sy_ff)) >>> 30);
         x1_4_ff <= x1_3_ff;
         y1_4_ff <= y1_3_ff;
      end
   end

   // stage 5: k2 term, tangential sums
   localparam int PB_W = COEF_W + R4_W;
   logic signed [B_W-1:0]  b_ff;
   logic signed [A_W-1:0]  a_5_ff;
   logic signed [T_W-1:0]  tx_5_ff, ty_5_ff;
   logic signed [X1_W-1:0] x1_5_ff, y1_5_ff;
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         b_ff    <= B_W'((PB_W'(cfg.k2) * PB_W'(r4_ff)) >>> 28);
         a_5_ff  <= a_4_ff;
         tx_5_ff <= tx1_ff + tx2_ff;
         ty_5_ff <= ty1_ff + ty2_ff;
         x1_5_ff <= x1_4_ff;
         y1_5_ff <= y1_4_ff;
      end
   end

   // stage 6: radial factor
   logic signed [F_W-1:0]  f_ff;
   logic signed [T_W-1:0]  tx_6_ff, ty_6_ff;
   logic signed [X1_W-1:0] x1_6_ff, y1_6_ff;
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         f_ff    <= F_W'(ONE_Q24) + F_W'(a_5_ff) + F_W'(b_ff);
         tx_6_ff <= tx_5_ff;
         ty_6_ff <= ty_5_ff;
         x1_6_ff <= x1_5_ff;
         y1_6_ff <= y1_5_ff;
      end
   end

   // stage 7: scale by radial factor
   localparam int PF_W = X1_W + F_W;
   logic signed [V_W-1:0] mx_ff, my_ff;
   logic signed [T_W-1:0] tx_7_ff, ty_7_ff;
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         mx_ff   <= V_W'((PF_W'(x1_6_ff) * PF_W'(f_ff)) >>> 24);
         my_ff   <= V_W'((PF_W'(y1_6_ff) * PF_W'(f_ff)) >>> 24);
         tx_7_ff <= tx_6_ff;
         ty_7_ff <= ty_6_ff;
      end
   end

   // stage 8: add tangential part, remove gun offset from y
   logic signed [V_W-1:0] vx_ff, vy_ff;
   always_ff @(posedge clock) begin
      if (adv[8]) begin
         vx_ff <= mx_ff + V_W'(tx_7_ff);
         vy_ff <= my_ff + V_W'(ty_7_ff) - V_W'(cfg.goff);
      end
   end

   assign out_valid = v_ff[NF-1];
   assign out_rune  = rune_ff[NF-1];
   assign vx        = vx_ff;
   assign vy        = vy_ff;

endmodule
`default_nettype wire

>>> hdl/pta_cordic.sv
// Two-lane vectoring CORDIC arctangent in degrees, one register stage per step.
`default_nettype none
module pta_cordic
   import pta_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic signed [V_W-1:0] vx,
   input  wire logic signed [V_W-1:0] vy,
   input  wire logic              in_rune,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic signed [Z_W-1:0]  zx,
   output logic signed [Z_W-1:0]  zy,
   output logic                   out_rune
);

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] rune_ff;
   logic [STAGES:0]   adv;

   logic signed [CW-1:0]  x_ff [STAGES][2];
   logic signed [CW-1:0]  y_ff [STAGES][2];
   logic signed [Z_W-1:0] z_ff [STAGES][2];

   assign adv[STAGES] = out_ready;
   for (genvar k = 0; k < STAGES; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            rune_ff[k] <= (k == 0) ? in_rune : rune_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [CW-1:0]  x_prev, y_prev, x_in, y_in;
         logic signed [Z_W-1:0] z_prev, z_in;
         if (k == 0) begin : g_first
            assign x_prev = CW'(ONE_Q24);
            assign y_prev = (l == 0) ? CW'(vx) : CW'(vy);
            assign z_prev = '0;
         end else begin : g_next
            assign x_prev = x_ff[k-1][l];
            assign y_prev = y_ff[k-1][l];
            assign z_prev = z_ff[k-1][l];
         end
         // rotate toward the x axis; the sign of y picks the direction
         always_comb begin
            if (!y_prev[CW-1]) begin
               x_in = x_prev + (y_prev >>> k);
               y_in = y_prev - (x_prev >>> k);
               z_in = z_prev + ATAN_DEG_Q24[k];
            end else begin
               x_in = x_prev - (y_prev >>> k);
               y_in = y_prev + (x_prev >>> k);
               z_in = z_prev - ATAN_DEG_Q24[k];
            end
         end
         always_ff @(posedge clock) begin
            if (adv[k]) begin
               x_ff[k][l] <= x_in;
               y_ff[k][l] <= y_in;
               z_ff[k][l] <= z_in;
            end
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_rune  = rune_ff[STAGES-1];
   assign zx        = z_ff[STAGES-1][0];
   assign zy        = z_ff[STAGES-1][1];

endmodule
`default_nettype wire
